// ===== rtl/core/tclp_pkg.sv =====
// Package for the train command line parser.
// Holds the parse phase type, character and code constants and the result record.
// No dependencies.
package tclp_pkg;

  localparam int NUM_SWITCHES = 32;
  localparam int SW_IDX_W     = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  typedef enum logic [4:0] {
    PH_START, PH_T, PH_TR_SEP, PH_TR_B1, PH_TR_N1, PH_TR_B2, PH_TR_N2,
    PH_TR_TAIL, PH_R, PH_RV_SEP, PH_RV_B1, PH_RV_N, PH_RV_TAIL, PH_S,
    PH_SW_SEP, PH_SW_B1, PH_SW_ZERO, PH_SW_ZX, PH_SW_HEX9, PH_SW_DEC,
    PH_SW_SKIP, PH_SW_BLANK, PH_SW_TAIL, PH_Q_TAIL, PH_ERR
  } phase_t;

  localparam logic [2:0] KIND_INVALID = 3'd0;
  localparam logic [2:0] KIND_SPEED   = 3'd1;
  localparam logic [2:0] KIND_REVERSE = 3'd2;
  localparam logic [2:0] KIND_SWITCH  = 3'd3;
  localparam logic [2:0] KIND_QUIT    = 3'd4;

  localparam logic [7:0] CODE_REVERSE  = 8'd15;
  localparam logic [7:0] CODE_STRAIGHT = 8'd33;
  localparam logic [7:0] CODE_CURVED   = 8'd34;
  localparam logic [7:0] CODE_SOL_OFF  = 8'd32;
  localparam logic [7:0] HEX_SW_BASE   = 8'h99;
  localparam logic [7:0] HEX_POS_BASE  = 8'd19;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UB  = 8'h42;
  localparam logic [7:0] CH_UC  = 8'h43;
  localparam logic [7:0] CH_US  = 8'h53;
  localparam logic [7:0] CH_Q   = 8'h71;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_W   = 8'h77;
  localparam logic [7:0] CH_X   = 8'h78;

  typedef struct packed {
    logic [2:0] cmd_kind;
    logic [1:0] byte_count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       switch_written;
    logic [7:0] switch_index;
    logic       switch_curved;
    logic       index_overflow;
  } res_t;

endpackage

// ===== rtl/core/tclp_parse.sv =====
// Parse state machine and switch direction table of the train command line parser.
// Consumes one character per step; flags and builds a result at CR or LF.
// Depends on tclp_pkg.
module tclp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  output logic              res_valid,
  output tclp_pkg::res_t    res
);

  tclp_pkg::phase_t ph_r, ph_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [1:0] lws_r, lws_nxt;
  logic       table_r [tclp_pkg::NUM_SWITCHES];

  logic       wr_en;
  logic       wr_val;
  logic       blank, digit, skip, eol;
  logic       after_num, dir_hit, dir_curved;
  logic [11:0] acc_wide;
  logic [7:0] acc_step;
  logic [1:0] hex_k;

  assign blank = (ch == tclp_pkg::CH_SP) || (ch == tclp_pkg::CH_TAB);
  assign digit = (ch >= tclp_pkg::CH_0) && (ch <= tclp_pkg::CH_9);
  assign skip  = digit || (ch == tclp_pkg::CH_UA) || (ch == tclp_pkg::CH_UB) ||
                 (ch == tclp_pkg::CH_UC) || (ch == tclp_pkg::CH_X);
  assign eol   = (ch == tclp_pkg::CH_CR) || (ch == tclp_pkg::CH_LF);

  // acc * 10 + digit, saturating at 255
  assign acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {8'd0, ch[3:0]};
  assign acc_step = (acc_wide > 12'd255) ? 8'hFF : acc_wide[7:0];

  // '9' -> 0, 'A'..'C' -> 1..3 (low two bits of the letter)
  assign hex_k = (ch == tclp_pkg::CH_9) ? 2'd0 : ch[1:0];

  always_comb begin
    ph_nxt     = ph_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    code_nxt   = code_r;
    pos_nxt    = pos_r;
    lws_nxt    = lws_r;
    wr_en      = 1'b0;
    wr_val     = 1'b0;
    after_num  = 1'b0;
    dir_hit    = 1'b0;
    dir_curved = 1'b0;
    unique case (ph_r)
      tclp_pkg::PH_START: begin
        if (!blank) begin
          if (ch == tclp_pkg::CH_T)      ph_nxt = tclp_pkg::PH_T;
          else if (ch == tclp_pkg::CH_R) ph_nxt = tclp_pkg::PH_R;
          else if (ch == tclp_pkg::CH_S) ph_nxt = tclp_pkg::PH_S;
          else if (ch == tclp_pkg::CH_Q) ph_nxt = tclp_pkg::PH_Q_TAIL;
          else                           ph_nxt = tclp_pkg::PH_ERR;
        end
      end
      tclp_pkg::PH_T:
        ph_nxt = (ch == tclp_pkg::CH_R) ? tclp_pkg::PH_TR_SEP : tclp_pkg::PH_ERR;
      tclp_pkg::PH_R:
        ph_nxt = (ch == tclp_pkg::CH_V) ? tclp_pkg::PH_RV_SEP : tclp_pkg::PH_ERR;
      tclp_pkg::PH_S:
        ph_nxt = (ch == tclp_pkg::CH_W) ? tclp_pkg::PH_SW_SEP : tclp_pkg::PH_ERR;
      tclp_pkg::PH_TR_SEP: ph_nxt = blank ? tclp_pkg::PH_TR_B1 : tclp_pkg::PH_ERR;
      tclp_pkg::PH_RV_SEP: ph_nxt = blank ? tclp_pkg::PH_RV_B1 : tclp_pkg::PH_ERR;
      tclp_pkg::PH_SW_SEP: ph_nxt = blank ? tclp_pkg::PH_SW_B1 : tclp_pkg::PH_ERR;
      tclp_pkg::PH_TR_B1, tclp_pkg::PH_TR_B2, tclp_pkg::PH_RV_B1: begin
        if (!blank) begin
          if (digit) begin
            acc_nxt = acc_step;
            if (ph_r == tclp_pkg::PH_TR_B1)      ph_nxt = tclp_pkg::PH_TR_N1;
            else if (ph_r == tclp_pkg::PH_TR_B2) ph_nxt = tclp_pkg::PH_TR_N2;
            else                                 ph_nxt = tclp_pkg::PH_RV_N;
          end else begin
            ph_nxt = tclp_pkg::PH_ERR;
          end
        end
      end
      tclp_pkg::PH_TR_N1: begin
        if (digit) acc_nxt = acc_step;
        else if (blank) begin
          first_nxt = acc_r;
          acc_nxt   = 8'd0;
          ph_nxt    = tclp_pkg::PH_TR_B2;
        end else ph_nxt = tclp_pkg::PH_ERR;
      end
      tclp_pkg::PH_TR_N2, tclp_pkg::PH_RV_N: begin
        if (digit) acc_nxt = acc_step;
        else if (blank) begin
          ph_nxt = (ph_r == tclp_pkg::PH_TR_N2) ? tclp_pkg::PH_TR_TAIL
                                                : tclp_pkg::PH_RV_TAIL;
        end else ph_nxt = tclp_pkg::PH_ERR;
      end
      tclp_pkg::PH_TR_TAIL, tclp_pkg::PH_RV_TAIL, tclp_pkg::PH_SW_TAIL,
      tclp_pkg::PH_Q_TAIL: begin
        if (!blank) ph_nxt = tclp_pkg::PH_ERR;
      end
      tclp_pkg::PH_SW_B1: begin
        if (!blank) begin
          if (digit) begin
            acc_nxt = acc_step;
            ph_nxt  = (ch == tclp_pkg::CH_0) ? tclp_pkg::PH_SW_ZERO : tclp_pkg::PH_SW_DEC;
          end else ph_nxt = tclp_pkg::PH_ERR;
        end
      end
      tclp_pkg::PH_SW_ZERO: begin
        if (ch == tclp_pkg::CH_X) begin
          first_nxt = acc_r;
          pos_nxt   = acc_r;
          ph_nxt    = tclp_pkg::PH_SW_ZX;
        end else if (digit) begin
          acc_nxt = acc_step;
          ph_nxt  = tclp_pkg::PH_SW_DEC;
        end else begin
          first_nxt = acc_r;
          pos_nxt   = acc_r;
          after_num = 1'b1;
        end
      end
      tclp_pkg::PH_SW_ZX: begin
        if (ch == tclp_pkg::CH_9) ph_nxt = tclp_pkg::PH_SW_HEX9;
        else after_num = 1'b1;
      end
      tclp_pkg::PH_SW_HEX9: begin
        if ((ch == tclp_pkg::CH_9) || (ch == tclp_pkg::CH_UA) ||
            (ch == tclp_pkg::CH_UB) || (ch == tclp_pkg::CH_UC)) begin
          first_nxt = tclp_pkg::HEX_SW_BASE + {6'd0, hex_k};
          pos_nxt   = tclp_pkg::HEX_POS_BASE + {6'd0, hex_k};
          ph_nxt    = tclp_pkg::PH_SW_SKIP;
        end else ph_nxt = tclp_pkg::PH_ERR;
      end
      tclp_pkg::PH_SW_DEC: begin
        if (digit) acc_nxt = acc_step;
        else begin
          first_nxt = acc_r;
          pos_nxt   = acc_r;
          after_num = 1'b1;
        end
      end
      tclp_pkg::PH_SW_SKIP: after_num = 1'b1;
      tclp_pkg::PH_SW_BLANK: begin
        if (!blank) begin
          if (ch == tclp_pkg::CH_US) dir_hit = 1'b1;
          else if (ch == tclp_pkg::CH_UC) begin
            dir_hit    = 1'b1;
            dir_curved = 1'b1;
          end else ph_nxt = tclp_pkg::PH_ERR;
        end
      end
      default: ph_nxt = tclp_pkg::PH_ERR;
    endcase

    if (after_num) begin
      if (ch == tclp_pkg::CH_US) dir_hit = 1'b1;
      else if (blank)            ph_nxt = tclp_pkg::PH_SW_BLANK;
      else if (skip)             ph_nxt = tclp_pkg::PH_SW_SKIP;
      else                       ph_nxt = tclp_pkg::PH_ERR;
    end

    if (dir_hit) begin
      code_nxt = dir_curved ? tclp_pkg::CODE_CURVED : tclp_pkg::CODE_STRAIGHT;
      if ({1'b0, pos_nxt} < 9'(tclp_pkg::NUM_SWITCHES)) begin
        wr_en   = 1'b1;
        wr_val  = dir_curved;
        lws_nxt = {lws_r[1], 1'b1};
      end else begin
        lws_nxt = {1'b1, lws_r[0]};
      end
      ph_nxt = tclp_pkg::PH_SW_TAIL;
    end
  end

  assign res_valid = eol;

  always_comb begin
    res = '0;
    unique case (ph_r)
      tclp_pkg::PH_TR_N2, tclp_pkg::PH_TR_TAIL: begin
        res.cmd_kind   = tclp_pkg::KIND_SPEED;
        res.byte_count = 2'd2;
        res.byte0      = acc_r;
        res.byte1      = first_r;
      end
      tclp_pkg::PH_RV_N, tclp_pkg::PH_RV_TAIL: begin
        res.cmd_kind   = tclp_pkg::KIND_REVERSE;
        res.byte_count = 2'd2;
        res.byte0      = tclp_pkg::CODE_REVERSE;
        res.byte1      = acc_r;
      end
      tclp_pkg::PH_SW_TAIL: begin
        res.cmd_kind   = tclp_pkg::KIND_SWITCH;
        res.byte_count = 2'd3;
        res.byte0      = code_r;
        res.byte1      = first_r;
        res.byte2      = tclp_pkg::CODE_SOL_OFF;
      end
      tclp_pkg::PH_Q_TAIL: res.cmd_kind = tclp_pkg::KIND_QUIT;
      default: res.cmd_kind = tclp_pkg::KIND_INVALID;
    endcase
    res.switch_written = lws_r[0];
    res.switch_index   = (lws_r != 2'd0) ? pos_r : 8'd0;
    res.switch_curved  = lws_r[0] ? table_r[pos_r[tclp_pkg::SW_IDX_W-1:0]] : 1'b0;
    res.index_overflow = lws_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= tclp_pkg::PH_START;
      acc_r   <= 8'd0;
      first_r <= 8'd0;
      code_r  <= 8'd0;
      pos_r   <= 8'd0;
      lws_r   <= 2'd0;
      for (int i = 0; i < tclp_pkg::NUM_SWITCHES; i++) table_r[i] <= 1'b0;
    end else if (step) begin
      if (eol) begin
        ph_r    <= tclp_pkg::PH_START;
        acc_r   <= 8'd0;
        first_r <= 8'd0;
        code_r  <= 8'd0;
        pos_r   <= 8'd0;
        lws_r   <= 2'd0;
      end else begin
        ph_r    <= ph_nxt;
        acc_r   <= acc_nxt;
        first_r <= first_nxt;
        code_r  <= code_nxt;
        pos_r   <= pos_nxt;
        lws_r   <= lws_nxt;
        if (wr_en) table_r[pos_nxt[tclp_pkg::SW_IDX_W-1:0]] <= wr_val;
      end
    end
  end

endmodule

// ===== rtl/core/train_command_line_parser.sv =====
// Top level of the train command line parser.
// Input character register, parser instance and result register.
// Depends on tclp_pkg and tclp_parse.
//
// Usage:
//   in_*  : one ASCII character per transfer in in_tdata.
//   out_* : one result per CR or LF character; other characters give none.
//           out_tuser carries the command kind, out_tdata the bytes and
//           switch table status.
// Timing: a character in the input register is parsed when it advances, which
//   also loads a line result into the result register and raises out_tvalid;
//   the result then transfers when out_tready is high.
// Throughput: one character per cycle while no line terminator waits on a
//   stalled result; the parse step lies between the input and result registers.
// Reset: parse state returns to line start, all switches to straight, both
//   registers empty.
// Stall: while a result waits on out_tready, non-terminator characters keep
//   flowing; a line terminator waits in the input register, and in_tready
//   drops only once that register is also occupied.
module train_command_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] byte_count, [9:2] byte0, [17:10] byte1,
                                  // [25:18] byte2, [26] switch_written,
                                  // [34:27] switch_index, [35] switch_curved,
                                  // [36] index_overflow, [39:37] zero
  output logic [2:0]  out_tuser   // [2:0] cmd_kind
);

  logic           in_valid_r;
  logic [7:0]     ch_r;
  logic           out_valid_r, out_valid_nxt;
  tclp_pkg::res_t res_r;
  tclp_pkg::res_t res;
  logic           res_valid;
  logic           advance;
  logic           load;

  tclp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .ch        (ch_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance   = in_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign load      = advance && res_valid;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) ch_r <= in_tdata;
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.cmd_kind;
  assign out_tdata  = {3'b000, res_r.index_overflow, res_r.switch_curved,
                       res_r.switch_index, res_r.switch_written, res_r.byte2,
                       res_r.byte1, res_r.byte0, res_r.byte_count};

  a_invalid_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.cmd_kind == tclp_pkg::KIND_INVALID) |-> res_r.byte_count == 2'd0)
    else $error("invalid result carries bytes");

  a_write_xor_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.switch_written && res_r.index_overflow))
    else $error("switch written and overflow on the same line");

  a_switch_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.cmd_kind == tclp_pkg::KIND_SWITCH) |->
      (res_r.byte_count == 2'd3) && (res_r.byte2 == tclp_pkg::CODE_SOL_OFF))
    else $error("switch result malformed");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && res_valid && out_valid_r && !out_tready |=> in_valid_r && $stable(ch_r))
    else $error("terminator dropped while result stalled");

endmodule
